@@ hdl/dense_graph_shortest_path_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dense graph shortest path block
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATH_DEFINES_SVH
`define DENSE_GRAPH_SHORTEST_PATH_DEFINES_SVH

// Check a property outside of reset.
`define DGSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check a property at every edge, reset included.
`define DGSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/dgsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path package
// Opcodes, controller states, field widths and the command/status structs.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  localparam int NODE_FW     = 4;
  localparam int WEIGHT_W    = 8;
  localparam int COST_W      = 12;
  localparam int OUT_LIMIT   = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_EDGE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_EDGE2,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_NEXT,
    ST_CHECK,
    ST_COST,
    ST_PUSH,
    ST_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_BAD
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic clr_step;
    logic wr_weight;
    logic wr_edge_ab;
    logic wr_edge_ba;
    logic init;
    logic scan;
    logic settle;
    logic cost_rd;
    logic cost_ld;
    logic bt_push;
    logic bt_rd;
    logic bt_ld;
    logic emit_rd;
    logic emit_ld;
    logic bad_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_t  op;
    logic nodes_ok;
    logic graph_ok;
    logic scan_last;
    logic found;
    logic dst_valid;
    logic bt_stop;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/dgsp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module dgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/dgsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path controller
// Sequences table writes, the settle/relax rounds, backtrack and emission.
// ----------------------------------------------------------------------------
module dgsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dgsp_pkg::sts_t sts,
  output dgsp_pkg::cmd_t cmd
);

  import dgsp_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.op)
          OP_WEIGHT: begin
            cmd.wr_weight = sts.nodes_ok;
            state_nxt     = ST_IDLE;
          end
          OP_EDGE: begin
            if (sts.nodes_ok && sts.graph_ok) begin
              cmd.wr_edge_ab = 1'b1;
              state_nxt      = ST_EDGE2;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          OP_QUERY: begin
            state_nxt = (sts.nodes_ok && sts.graph_ok) ? ST_INIT : ST_BAD;
          end
          OP_NONE: begin
            state_nxt = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EDGE2: begin
        cmd.wr_edge_ba = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts.found) begin
          cmd.settle = 1'b1;
          state_nxt  = ST_SCAN;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.dst_valid) begin
          cmd.cost_rd = 1'b1;
          state_nxt   = ST_COST;
        end else begin
          state_nxt = ST_BAD;
        end
      end
      ST_COST: begin
        cmd.cost_ld = 1'b1;
        state_nxt   = ST_PUSH;
      end
      ST_PUSH: begin
        cmd.bt_push = 1'b1;
        if (sts.bt_stop) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          cmd.bt_rd = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd.bt_ld = 1'b1;
        state_nxt = ST_PUSH;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_BAD: begin
        if (sts.out_free) begin
          cmd.bad_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/dgsp_dpath.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path datapath
// Weight and adjacency RAMs, distance/predecessor/stack RAMs, the
// relax-and-select scan pipeline and the result register.
// ----------------------------------------------------------------------------
module dgsp_dpath #(
  parameter int NODES  = 16,
  parameter int GRAPHS = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dgsp_pkg::cmd_t                  cmd,
  output dgsp_pkg::sts_t                  sts,
  input  logic [1:0]                      in_opcode,
  input  logic                            in_graph_sel,
  input  logic [dgsp_pkg::NODE_FW-1:0]    in_node_a,
  input  logic [dgsp_pkg::NODE_FW-1:0]    in_node_b,
  input  logic [dgsp_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic                            in_edge_present,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [dgsp_pkg::NODE_FW-1:0]    out_path_node,
  output logic [dgsp_pkg::COST_W-1:0]     out_total_cost,
  output logic                            out_reachable,
  output logic                            out_last
);

  import dgsp_pkg::*;

  localparam int NW  = $clog2(NODES);
  localparam int NN  = NODES * NODES;
  localparam int WAW = $clog2(NN);
  localparam int AAD = GRAPHS * NN;
  localparam int AAW = $clog2(AAD);
  localparam int DW  = $clog2(NODES + 1);

  localparam logic [NODE_FW:0] NODE_LIM  = (NODES > 16) ? 5'd16 : 5'(NODES);
  localparam logic [1:0]       GRAPH_LIM = (GRAPHS > 2) ? 2'd2 : 2'(GRAPHS);

  // latched item
  op_t                 op_r, op_nxt;
  logic                g_r, g_nxt;
  logic [NODE_FW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic                e_r, e_nxt;

  // clearing pass
  logic [AAW-1:0] clr_cnt_r, clr_cnt_nxt;

  // scan pipeline
  logic [NW-1:0]     i_r, i_nxt, i_p_r, i_p_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic [NW-1:0]     u_r, u_nxt;
  logic [COST_W-1:0] du_r, du_nxt;
  logic [NODES-1:0]  settled_r, settled_nxt, valid_r, valid_nxt;
  logic              found_r, found_nxt;
  logic [COST_W-1:0] best_r, best_nxt;
  logic [NW-1:0]     best_idx_r, best_idx_nxt;

  // backtrack and emission
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [3:0]        k_r, k_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [NODE_FW-1:0] out_node_r, out_node_nxt;
  logic [COST_W-1:0]  out_cost_r, out_cost_nxt;
  logic               out_reach_r, out_reach_nxt;
  logic               out_last_r, out_last_nxt;

  // RAM ports
  logic [WEIGHT_W-1:0] w_rdata;
  logic                adj_rdata;
  logic [COST_W-1:0]   dist_rdata;
  logic [NW-1:0]       pred_rdata, stack_rdata;
  logic                adj_we, dist_we, pred_we;
  logic [AAW-1:0]      adj_waddr, adj_raddr;
  logic [WAW-1:0]      w_waddr, w_raddr;
  logic [NW-1:0]       src, dst;
  logic [DW-1:0]       depth_m1;

  // fold stage
  logic              fold_st, fold_vl, relax, eff_vld, take;
  logic [COST_W:0]   wsum;
  logic [COST_W-1:0] nd, eff;

  assign src      = NW'(a_r);
  assign dst      = NW'(b_r);
  assign depth_m1 = depth_r - DW'(1);

  // status to the controller
  assign sts.clr_last  = (clr_cnt_r == AAW'(AAD - 1));
  assign sts.op        = op_r;
  assign sts.nodes_ok  = ({1'b0, a_r} < NODE_LIM) && ({1'b0, b_r} < NODE_LIM);
  assign sts.graph_ok  = ({1'b0, g_r} < GRAPH_LIM);
  assign sts.scan_last = (i_r == NW'(NODES - 1));
  assign sts.found     = found_r;
  assign sts.dst_valid = valid_r[dst];
  assign sts.bt_stop   = (n_r == src) || (depth_r == DW'(NODES - 1));
  assign sts.emit_last = (depth_r == DW'(1)) || (k_r == 4'(OUT_LIMIT - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // relax the node read last cycle and fold it into the running minimum
  always_comb begin
    fold_st = settled_r[i_p_r];
    fold_vl = valid_r[i_p_r];
    wsum    = {1'b0, du_r} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, w_rdata};
    nd      = wsum[COST_W] ? COST_MAX : wsum[COST_W-1:0];
    relax   = p_vld_r && !fold_st && adj_rdata && (!fold_vl || (nd < dist_rdata));
    eff     = relax ? nd : dist_rdata;
    eff_vld = fold_vl || relax;
    take    = p_vld_r && !fold_st && eff_vld && (!found_r || (eff < best_r));
  end

  // weight table
  assign w_waddr = WAW'(NW'(a_r) * NODES + NW'(b_r));
  assign w_raddr = WAW'(u_r * NODES + i_r);

  dgsp_ram #(.WIDTH(WEIGHT_W), .DEPTH(NN)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.wr_weight),
    .waddr (w_waddr),
    .wdata (w_r),
    .re    (cmd.scan),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // adjacency bits, cleared after reset, written in both directions
  always_comb begin
    adj_we = cmd.clr_step || cmd.wr_edge_ab || cmd.wr_edge_ba;
    priority if (cmd.clr_step) begin
      adj_waddr = clr_cnt_r;
    end else if (cmd.wr_edge_ab) begin
      adj_waddr = AAW'(g_r * NN + NW'(a_r) * NODES + NW'(b_r));
    end else begin
      adj_waddr = AAW'(g_r * NN + NW'(b_r) * NODES + NW'(a_r));
    end
  end
  assign adj_raddr = AAW'(g_r * NN + u_r * NODES + i_r);

  dgsp_ram #(.WIDTH(1), .DEPTH(AAD)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (e_r && !cmd.clr_step),
    .re    (cmd.scan),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // distances and predecessors
  assign dist_we = cmd.init || relax;
  assign pred_we = cmd.init || relax;

  dgsp_ram #(.WIDTH(COST_W), .DEPTH(NODES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (cmd.init ? src : i_p_r),
    .wdata (cmd.init ? '0 : nd),
    .re    (cmd.scan || cmd.cost_rd),
    .raddr (cmd.cost_rd ? dst : i_r),
    .rdata (dist_rdata)
  );

  dgsp_ram #(.WIDTH(NW), .DEPTH(NODES)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (cmd.init ? src : i_p_r),
    .wdata (cmd.init ? src : u_r),
    .re    (cmd.bt_rd),
    .raddr (n_r),
    .rdata (pred_rdata)
  );

  // reversed path, destination first
  dgsp_ram #(.WIDTH(NW), .DEPTH(NODES)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.bt_push),
    .waddr (depth_r[NW-1:0]),
    .wdata (n_r),
    .re    (cmd.emit_rd),
    .raddr (depth_m1[NW-1:0]),
    .rdata (stack_rdata)
  );

  // next values
  always_comb begin
    op_nxt        = op_r;
    g_nxt         = g_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    w_nxt         = w_r;
    e_nxt         = e_r;
    clr_cnt_nxt   = clr_cnt_r;
    i_nxt         = i_r;
    i_p_nxt       = i_r;
    p_vld_nxt     = cmd.scan;
    u_nxt         = u_r;
    du_nxt        = du_r;
    settled_nxt   = settled_r;
    valid_nxt     = valid_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    cost_nxt      = cost_r;
    n_nxt         = n_r;
    depth_nxt     = depth_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_node_nxt  = out_node_r;
    out_cost_nxt  = out_cost_r;
    out_reach_nxt = out_reach_r;
    out_last_nxt  = out_last_r;

    // capture the accepted item
    if (cmd.latch_in) begin
      op_nxt = op_t'(in_opcode);
      g_nxt  = in_graph_sel;
      a_nxt  = in_node_a;
      b_nxt  = in_node_b;
      w_nxt  = in_weight;
      e_nxt  = in_edge_present;
    end

    if (cmd.clr_step) clr_cnt_nxt = clr_cnt_r + 1'b1;

    // advance the scan index
    if (cmd.scan) i_nxt = i_r + 1'b1;

    // fold stage updates
    if (relax) valid_nxt[i_p_r] = 1'b1;
    if (take) begin
      found_nxt    = 1'b1;
      best_nxt     = eff;
      best_idx_nxt = i_p_r;
    end

    // start a query with the source settled at distance zero
    if (cmd.init) begin
      settled_nxt      = '0;
      settled_nxt[src] = 1'b1;
      valid_nxt        = '0;
      valid_nxt[src]   = 1'b1;
      u_nxt            = src;
      du_nxt           = '0;
      i_nxt            = '0;
      found_nxt        = 1'b0;
    end

    // settle the round's minimum and restart the scan
    if (cmd.settle) begin
      settled_nxt[best_idx_r] = 1'b1;
      u_nxt                   = best_idx_r;
      du_nxt                  = best_r;
      i_nxt                   = '0;
      found_nxt               = 1'b0;
    end

    if (cmd.cost_ld) begin
      cost_nxt  = dist_rdata;
      n_nxt     = dst;
      depth_nxt = '0;
      k_nxt     = '0;
    end

    if (cmd.bt_push) depth_nxt = depth_r + 1'b1;
    if (cmd.bt_ld) n_nxt = pred_rdata;

    // load one path node
    if (cmd.emit_ld) begin
      out_valid_nxt = 1'b1;
      out_node_nxt  = NODE_FW'(stack_rdata);
      out_cost_nxt  = cost_r;
      out_reach_nxt = 1'b1;
      out_last_nxt  = sts.emit_last;
      depth_nxt     = depth_m1;
      k_nxt         = k_r + 1'b1;
    end

    // load the unreachable result
    if (cmd.bad_ld) begin
      out_valid_nxt = 1'b1;
      out_node_nxt  = '0;
      out_cost_nxt  = '0;
      out_reach_nxt = 1'b0;
      out_last_nxt  = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      p_vld_r     <= 1'b0;
      settled_r   <= '0;
      valid_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      settled_r   <= settled_nxt;
      valid_r     <= valid_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    g_r        <= g_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    w_r        <= w_nxt;
    e_r        <= e_nxt;
    i_r        <= i_nxt;
    i_p_r      <= i_p_nxt;
    u_r        <= u_nxt;
    du_r       <= du_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    cost_r     <= cost_nxt;
    n_r        <= n_nxt;
    depth_r    <= depth_nxt;
    k_r        <= k_nxt;
    out_node_r <= out_node_nxt;
    out_cost_r <= out_cost_nxt;
    out_reach_r <= out_reach_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_path_node  = out_node_r;
  assign out_total_cost = out_cost_r;
  assign out_reachable  = out_reach_r;
  assign out_last       = out_last_r;

endmodule

@@ hdl/dense_graph_shortest_path.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path
// Dijkstra over an adjacency matrix: loads weights and edge bits, answers
// path queries with one item per path node, source first.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  in_     | slave     | tuser: opcode; tdata: graph_sel, node_a, node_b,
//          |           |        weight, edge_present
//  out_    | master    | tuser: reachable; tdata: path_node, total_cost;
//          |           | tlast: last
//
// After reset a clearing pass zeroes the GRAPHS*NODES*NODES entries of the
// adjacency RAM; in_tready stays low meanwhile.
// An edge write sets both directions. A query settles one node per round,
// each round a scan of every node through the weight and adjacency read
// ports; the path is then backtracked and emitted.
// A finished result waits in the output register while the next item is
// taken; emission stalls while that register is full and out_tready is low.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path #(
  parameter int NODES  = 16,
  parameter int GRAPHS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] graph_sel, [4:1] node_a, [8:5] node_b, [16:9] weight,
  // [17] edge_present, [23:18] zero
  input  logic [dgsp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] opcode
  input  logic [dgsp_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] path_node, [15:4] total_cost
  output logic [dgsp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] reachable
  output logic                                out_tuser,
  output logic                                out_tlast
);

  import dgsp_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [NODE_FW-1:0] path_node;
  logic [COST_W-1:0]  total_cost;

  dgsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dgsp_dpath #(.NODES(NODES), .GRAPHS(GRAPHS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_tuser[1:0]),
    .in_graph_sel    (in_tdata[0]),
    .in_node_a       (in_tdata[4:1]),
    .in_node_b       (in_tdata[8:5]),
    .in_weight       (in_tdata[16:9]),
    .in_edge_present (in_tdata[17]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_path_node   (path_node),
    .out_total_cost  (total_cost),
    .out_reachable   (out_tuser),
    .out_last        (out_tlast)
  );

  assign out_tdata = {total_cost, path_node};

endmodule

@@ hdl/dgsp_checker.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path checker
// Port-level assertions on the result stream and reset, bound to the top.
// ----------------------------------------------------------------------------
`include "dense_graph_shortest_path_defines.svh"

module dgsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dgsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  import dgsp_pkg::*;

  // a stalled result holds
  `DGSP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // an unreachable result ends its query
  `DGSP_ASSERT(a_unreach_last, out_tvalid && !out_tuser |-> out_tlast, "unreachable result without last")

  // an unreachable result carries no node and no cost
  `DGSP_ASSERT(a_unreach_zero, out_tvalid && !out_tuser |-> out_tdata == '0, "unreachable result with data")

  // in_tready is low right after reset, when the adjacency RAM clearing begins
  `DGSP_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> !in_tready, "item taken right after reset")

endmodule

bind dense_graph_shortest_path dgsp_checker u_dgsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ tb/dense_graph_shortest_path_checker.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path checker
// Watches both channels. Keeps its own weight and edge tables, works out the
// expected route items for every accepted query, and compares each emitted
// item with the oldest one waiting.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // [0] graph_sel, [4:1] node_a, [8:5] node_b, [16:9] weight,
  // [17] edge_present, [23:18] zero
  input  logic [dgsp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] opcode
  input  logic [dgsp_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] path_node, [15:4] total_cost
  input  logic [dgsp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] reachable
  input  logic                                out_tuser,
  input  logic                                out_tlast,
  output int                                  route_errors,
  output int                                  route_pending
);
  import dgsp_pkg::*;

  localparam int NODES  = 16;
  localparam int GRAPHS = 2;

  typedef struct packed {
    logic [NODE_FW-1:0] path_node;
    logic [COST_W-1:0]  total_cost;
    logic               reachable;
    logic               last;
  } route_item_t;

  logic [WEIGHT_W-1:0] weight_mem [NODES*NODES];
  bit                  edge_mem   [GRAPHS*NODES*NODES];
  route_item_t         route_q    [$];
  route_item_t         want;
  op_t                 in_op;
  logic                in_g;
  logic [NODE_FW-1:0]  in_a;
  logic [NODE_FW-1:0]  in_b;
  int                  err_count   = 0;
  int                  route_count = 0;

  assign route_errors  = err_count;
  assign route_pending = route_count;

  // Run Dijkstra on the local tables and queue the route items of one query
  function automatic void compute_route(input logic g, input logic [NODE_FW-1:0] src,
                                        input logic [NODE_FW-1:0] dst);
    logic [COST_W-1:0]  cost_at [NODES];
    bit                 reached [NODES];
    bit                 done    [NODES];
    logic [NODE_FW-1:0] pred    [NODES];
    logic [NODE_FW-1:0] trail   [NODES];
    logic [NODE_FW-1:0] hop;
    int                 u;
    int                 depth;
    int                 step;
    int                 sum;
    bit                 found;
    route_item_t        item;
    item = '0;
    if (int'(g) >= GRAPHS || int'(src) >= NODES || int'(dst) >= NODES) begin
      item.last = 1'b1;
      route_q.push_back(item);
      return;
    end
    for (int i = 0; i < NODES; i++) begin
      reached[i] = 1'b0;
      done[i]    = 1'b0;
      cost_at[i] = '0;
      pred[i]    = '0;
    end
    reached[src] = 1'b1;
    pred[src]    = src;

    // settle the closest open node, lowest index on ties, then relax
    for (int r = 0; r < NODES; r++) begin
      found = 1'b0;
      u     = 0;
      for (int i = 0; i < NODES; i++) begin
        if (!done[i] && reached[i] && (!found || cost_at[i] < cost_at[u])) begin
          u     = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      done[u] = 1'b1;
      for (int i = 0; i < NODES; i++) begin
        if (!done[i] && edge_mem[(int'(g) * NODES + u) * NODES + i]) begin
          sum = int'(cost_at[u]) + int'(weight_mem[u * NODES + i]);
          if (sum > int'(COST_MAX)) sum = int'(COST_MAX);
          if (!reached[i] || sum < int'(cost_at[i])) begin
            cost_at[i] = sum[COST_W-1:0];
            reached[i] = 1'b1;
            pred[i]    = u[NODE_FW-1:0];
          end
        end
      end
    end

    if (!reached[dst]) begin
      item.last = 1'b1;
      route_q.push_back(item);
      return;
    end

    // walk back from the destination, then emit source first
    depth = 0;
    hop   = dst;
    while (depth < NODES) begin
      trail[depth] = hop;
      depth++;
      if (hop == src) break;
      hop = pred[hop];
    end
    step = 0;
    while (depth > 0 && step < OUT_LIMIT) begin
      depth--;
      item.path_node  = trail[depth];
      item.total_cost = cost_at[dst];
      item.reachable  = 1'b1;
      item.last       = (depth == 0 || step == OUT_LIMIT - 1);
      route_q.push_back(item);
      step++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES * NODES; i++) weight_mem[i] = '0;
      for (int i = 0; i < GRAPHS * NODES * NODES; i++) edge_mem[i] = 1'b0;
      route_q.delete();
      route_count = 0;
    end else begin
      // compare an emitted item with the oldest expected one
      if (out_tvalid && out_tready) begin
        if (route_q.size() == 0) begin
          $error("route item with none expected: path_node %0d, total_cost %0d",
                 out_tdata[3:0], out_tdata[15:4]);
          err_count++;
        end else begin
          want = route_q.pop_front();
          if (out_tdata[3:0] !== want.path_node) begin
            $error("path_node: expected %0d, got %0d", want.path_node, out_tdata[3:0]);
            err_count++;
          end
          if (out_tdata[15:4] !== want.total_cost) begin
            $error("total_cost: expected %0d, got %0d", want.total_cost, out_tdata[15:4]);
            err_count++;
          end
          if (out_tuser !== want.reachable) begin
            $error("reachable: expected %0d, got %0d", want.reachable, out_tuser);
            err_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_tlast);
            err_count++;
          end
        end
      end

      // apply an accepted input item to the local tables
      if (in_tvalid && in_tready) begin
        in_op = op_t'(in_tuser);
        in_g  = in_tdata[0];
        in_a  = in_tdata[4:1];
        in_b  = in_tdata[8:5];
        case (in_op)
          OP_WEIGHT: begin
            weight_mem[int'(in_a) * NODES + int'(in_b)] = in_tdata[16:9];
          end
          OP_EDGE: begin
            if (int'(in_g) < GRAPHS) begin
              edge_mem[(int'(in_g) * NODES + int'(in_a)) * NODES + int'(in_b)] = in_tdata[17];
              edge_mem[(int'(in_g) * NODES + int'(in_b)) * NODES + int'(in_a)] = in_tdata[17];
            end
          end
          OP_QUERY: begin
            compute_route(in_g, in_a, in_b);
          end
          default: begin
          end
        endcase
      end
      route_count = route_q.size();
    end
  end

endmodule

@@ tb/tb_dense_graph_shortest_path.sv @@
// ----------------------------------------------------------------------------
// Dense graph shortest path testbench
// Loads weights and edges, fires path queries in bursts with random gaps,
// stalls the result side on its own pattern, and lets the checker judge
// every route item.
// ----------------------------------------------------------------------------
module tb_dense_graph_shortest_path;
  import dgsp_pkg::*;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  logic in_fire       = 1'b0;
  bit   long_hold_req = 1'b0;
  bit   weight_known [256];
  int   items_sent    = 0;
  int   burst_left    = 0;
  int   route_errors;
  int   route_pending;

  dense_graph_shortest_path i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dense_graph_shortest_path_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .route_errors  (route_errors),
    .route_pending (route_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Record input handshakes the way the block sees them
  always @(posedge clk) in_fire <= in_tvalid & in_tready;

  // Offer one item, idling between bursts; return once it is accepted
  task automatic send_item(input op_t op, input logic g, input logic [3:0] a,
                           input logic [3:0] b, input logic [7:0] w, input logic e);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, e, w, b, a, g};
    do @(negedge clk); while (in_fire !== 1'b1);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic send_weight(input logic [3:0] a, input logic [3:0] b, input logic [7:0] w);
    send_item(OP_WEIGHT, 1'($urandom_range(0, 1)), a, b, w, 1'($urandom_range(0, 1)));
    weight_known[{a, b}] = 1'b1;
  endtask

  // Set or clear an edge; load both weights first so a query never reads a blank one
  task automatic send_edge(input logic g, input logic [3:0] a, input logic [3:0] b,
                           input logic e);
    if (e) begin
      if (!weight_known[{a, b}]) send_weight(a, b, 8'($urandom_range(0, 255)));
      if (!weight_known[{b, a}]) send_weight(b, a, 8'($urandom_range(0, 255)));
    end
    send_item(OP_EDGE, g, a, b, 8'($urandom_range(0, 255)), e);
  endtask

  task automatic send_query(input logic g, input logic [3:0] a, input logic [3:0] b);
    send_item(OP_QUERY, g, a, b, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_query();
    send_query(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)));
  endtask

  // Lay a cheap chain through distinct nodes and query both of its ends
  task automatic build_chain(input logic g, input int len);
    logic [3:0] order [16];
    logic [3:0] tmp;
    int         j;
    for (int i = 0; i < 16; i++) order[i] = i[3:0];
    for (int i = 15; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i + 1 < len; i++) begin
      send_weight(order[i], order[i+1], 8'($urandom_range(0, 20)));
      send_weight(order[i+1], order[i], 8'($urandom_range(0, 20)));
      send_edge(g, order[i], order[i+1], 1'b1);
    end
    send_query(g, order[0], order[len-1]);
    send_query(g, order[len-1], order[0]);
  endtask

  // Stop offering until every expected route item has come out
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (route_pending != 0);
  endtask

  // Receiver: random stall modes, plus one long hold-off on request
  initial begin : result_sink
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        for (int c = 0; c < 1000; c++) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int pick;
    bit hold_done;
    bit drained;
    hold_done = 1'b0;
    drained   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty graph: unreachable destination; then source equals destination
    send_query(1'b0, 4'd0, 4'd5);
    send_query(1'b1, 4'd7, 4'd7);
    send_item(OP_NONE, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));

    // heaviest and lightest weights on the outermost node pair
    send_weight(4'd0, 4'd15, 8'd255);
    send_weight(4'd15, 4'd0, 8'd0);
    send_edge(1'b0, 4'd0, 4'd15, 1'b1);
    send_query(1'b0, 4'd0, 4'd15);
    send_query(1'b0, 4'd15, 4'd0);

    // two zero-cost detours: the lower index settles first and wins the tie
    send_weight(4'd0, 4'd1, 8'd0);
    send_weight(4'd1, 4'd0, 8'd255);
    send_weight(4'd1, 4'd15, 8'd0);
    send_weight(4'd0, 4'd2, 8'd0);
    send_weight(4'd2, 4'd15, 8'd0);
    send_edge(1'b0, 4'd0, 4'd1, 1'b1);
    send_edge(1'b0, 4'd1, 4'd15, 1'b1);
    send_edge(1'b0, 4'd0, 4'd2, 1'b1);
    send_edge(1'b0, 4'd2, 4'd15, 1'b1);
    send_query(1'b0, 4'd0, 4'd15);

    // drop the direct edge; self loop in the other graph
    send_edge(1'b0, 4'd0, 4'd15, 1'b0);
    send_query(1'b0, 4'd15, 4'd0);
    send_edge(1'b1, 4'd3, 4'd3, 1'b1);
    send_query(1'b1, 4'd3, 4'd3);
    send_query(1'b1, 4'd3, 4'd4);

    // random part: mostly chains and queries, with edge, weight and opcode noise
    while (items_sent < 220) begin
      pick = $urandom_range(0, 9);
      if (!hold_done && items_sent >= 80) begin
        hold_done     = 1'b1;
        long_hold_req = 1'b1;
        repeat (6) send_random_query();
      end else if (!drained && items_sent >= 150) begin
        drained = 1'b1;
        drain_wait();
      end else begin
        case (pick)
          0, 1, 2: begin
            build_chain(1'($urandom_range(0, 1)),
                        ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(2, 8));
          end
          3, 4: begin
            repeat ($urandom_range(1, 4))
              send_edge(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), ($urandom_range(0, 9) < 4));
          end
          5: begin
            repeat ($urandom_range(1, 3))
              send_weight(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)));
          end
          6, 7, 8: begin
            repeat ($urandom_range(1, 4)) send_random_query();
          end
          default: begin
            send_item(OP_NONE, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end
        endcase
      end
    end

    // let the last routes drain, then allow a full query time for strays
    in_tvalid <= 1'b0;
    while (route_pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (route_errors == 0) begin
      $display("tb_dense_graph_shortest_path: done, clean");
    end else begin
      $display("tb_dense_graph_shortest_path: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #6000000;
    $display("tb_dense_graph_shortest_path: done, errors");
    $finish;
  end

endmodule
